@@ design/ctb_pkg.sv @@
package ctb_pkg;

   // Screen and image geometry
   localparam int SCREEN_WIDTH   = 320;
   localparam int SCREEN_HEIGHT  = 200;
   localparam int MAX_IMAGE_SIDE = 1024;

   // Fixed field widths
   localparam int PIXEL_W = 8;
   localparam int ADDR_W  = 16;
   localparam int REG_W   = 11;
   localparam int IDX_W   = 3;

   // Configuration register indexes
   localparam logic [IDX_W-1:0] REG_DEST_X       = 3'd0;
   localparam logic [IDX_W-1:0] REG_DEST_Y       = 3'd1;
   localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd2;
   localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
   localparam logic [IDX_W-1:0] REG_TRANSPARENT  = 3'd4;

   // Source position counters and their limits
   localparam int COL_W = $clog2(MAX_IMAGE_SIDE);
   localparam int CNT_W = COL_W + 1;

   // Signed screen coordinate: destination plus source position
   localparam int SUM_W = ((COL_W > REG_W - 1) ? COL_W : REG_W - 1) + 2;

   // On-screen coordinate widths
   localparam int XW = $clog2(SCREEN_WIDTH);
   localparam int YW = $clog2(SCREEN_HEIGHT);

   // Address product width, never below the address field
   localparam int MUL_W = ((YW + XW + 1) > ADDR_W) ? (YW + XW + 1) : ADDR_W;

   // Queue between front and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [YW-1:0]      sy;
      logic [XW-1:0]      sx;
      logic [PIXEL_W-1:0] pixel;
   } blit_item_type;

   // Zero counts as one, anything above the largest side saturates.
   function automatic logic [CNT_W-1:0] clamp_side(input logic [REG_W-1:0] v);
      logic [31:0] v32;
      logic [31:0] r;
      v32 = 32'(v);
      if (v32 == 32'd0) begin
         r = 32'd1;
      end else if (v32 > 32'(MAX_IMAGE_SIDE)) begin
         r = 32'(MAX_IMAGE_SIDE);
      end else begin
         r = v32;
      end
      return r[CNT_W-1:0];
   endfunction

endpackage

@@ design/ctb_front.sv @@
module ctb_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [ctb_pkg::IDX_W-1:0]   csr_index,
   input  logic [ctb_pkg::REG_W-1:0]   csr_wdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ctb_pkg::PIXEL_W-1:0] req_tdata,
   input  logic                        req_tuser,
   input  logic                        queue_ready,
   output logic                        push,
   output ctb_pkg::blit_item_type      push_item
);
   import ctb_pkg::*;

   logic signed [REG_W-1:0] dest_x_ff, dest_x_in;
   logic signed [REG_W-1:0] dest_y_ff, dest_y_in;
   logic [CNT_W-1:0]        width_lim_ff, width_lim_in;
   logic [CNT_W-1:0]        height_lim_ff, height_lim_in;
   logic                    transparent_ff, transparent_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [COL_W-1:0]        row_ff, row_in;

   logic             accept;
   logic [COL_W-1:0] col_cur, row_cur;
   logic [CNT_W-1:0] col_inc, row_inc;
   logic [SUM_W-1:0] sum_x, sum_y;
   logic             on_screen;
   logic             keyed_out;

   assign req_tready = queue_ready;
   assign accept     = req_tvalid & queue_ready;

   // Register writes
   always_comb begin
      dest_x_in      = dest_x_ff;
      dest_y_in      = dest_y_ff;
      width_lim_in   = width_lim_ff;
      height_lim_in  = height_lim_ff;
      transparent_in = transparent_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_DEST_X:       dest_x_in      = csr_wdata;
            REG_DEST_Y:       dest_y_in      = csr_wdata;
            REG_IMAGE_WIDTH:  width_lim_in   = clamp_side(csr_wdata);
            REG_IMAGE_HEIGHT: height_lim_in  = clamp_side(csr_wdata);
            REG_TRANSPARENT:  transparent_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Position of this pixel; the first pixel restarts at the top left
   assign col_cur = req_tuser ? '0 : col_ff;
   assign row_cur = req_tuser ? '0 : row_ff;
   assign col_inc = CNT_W'(col_cur) + CNT_W'(1);
   assign row_inc = CNT_W'(row_cur) + CNT_W'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_inc >= width_lim_ff) begin
            col_in = '0;
            row_in = (row_inc >= height_lim_ff) ? '0 : row_inc[COL_W-1:0];
         end else begin
            col_in = col_inc[COL_W-1:0];
            row_in = row_cur;
         end
      end
   end

   // Screen coordinate and clip test
   assign sum_x = {{(SUM_W-REG_W){dest_x_ff[REG_W-1]}}, dest_x_ff} + SUM_W'(col_cur);
   assign sum_y = {{(SUM_W-REG_W){dest_y_ff[REG_W-1]}}, dest_y_ff} + SUM_W'(row_cur);

   assign on_screen = !sum_x[SUM_W-1] && (sum_x < SUM_W'(SCREEN_WIDTH))
                   && !sum_y[SUM_W-1] && (sum_y < SUM_W'(SCREEN_HEIGHT));
   assign keyed_out = transparent_ff && (req_tdata == '0);

   assign push            = accept && on_screen && !keyed_out;
   assign push_item.sx    = sum_x[XW-1:0];
   assign push_item.sy    = sum_y[YW-1:0];
   assign push_item.pixel = req_tdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_x_ff      <= '0;
         dest_y_ff      <= '0;
         width_lim_ff   <= CNT_W'(1);
         height_lim_ff  <= CNT_W'(1);
         transparent_ff <= 1'b0;
         col_ff         <= '0;
         row_ff         <= '0;
      end else begin
         dest_x_ff      <= dest_x_in;
         dest_y_ff      <= dest_y_in;
         width_lim_ff   <= width_lim_in;
         height_lim_ff  <= height_lim_in;
         transparent_ff <= transparent_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
      end
   end

endmodule

@@ design/ctb_queue.sv @@
module ctb_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ctb_pkg::blit_item_type push_item,
   output logic                   ready,
   output logic                   head_valid,
   output ctb_pkg::blit_item_type head_item,
   input  logic                   pop
);
   import ctb_pkg::*;

   blit_item_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign ready      = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   assign do_push = push && ready;
   assign do_pop  = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ design/ctb_back.sv @@
module ctb_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   input  ctb_pkg::blit_item_type      head_item,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ctb_pkg::ADDR_W+ctb_pkg::PIXEL_W-1:0] rsp_tdata
);
   import ctb_pkg::*;

   logic               out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0]  out_addr_ff, out_addr_in;
   logic [PIXEL_W-1:0] out_pixel_ff, out_pixel_in;
   logic [MUL_W-1:0]   addr_full;

   // Row times screen width plus column
   assign addr_full = MUL_W'(head_item.sy) * MUL_W'(SCREEN_WIDTH) + MUL_W'(head_item.sx);

   // Refill the output register when it is empty or being drained
   assign pop = head_valid && (!out_valid_ff || rsp_tready);

   always_comb begin
      out_valid_in = out_valid_ff;
      out_addr_in  = out_addr_ff;
      out_pixel_in = out_pixel_ff;
      if (pop) begin
         out_valid_in = 1'b1;
         out_addr_in  = addr_full[ADDR_W-1:0];
         out_pixel_in = head_item.pixel;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_pixel_ff, out_addr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_addr_ff  <= out_addr_in;
      out_pixel_ff <= out_pixel_in;
   end

endmodule

@@ design/clipped_transparent_blit_top.sv @@
// Clipped sprite blitter front end. Source pixels stream in raster order, one
// word per pixel, with tuser marking the first pixel of an image; the block
// places the image at the signed position (dest_x, dest_y) and emits a
// framebuffer write (address = row * screen width + column, and the pixel)
// only for pixels that land on screen and, in transparent mode, are not zero.
// Off-screen and keyed-out pixels are dropped, so the result stream carries
// zero or one word per source pixel. The block takes one pixel per clock while
// the queue has room: the front end clips and steps the column/row counters,
// a four-entry queue decouples it from the back end, and the back end forms the
// address with one constant multiply into the output register. A write passes
// through a queue slot and then the output register before it appears on rsp.
// Configuration registers are written through csr_* and are registered;
// write them only while no pixel is in flight. Image width and height of zero
// count as one, and values above the maximum image side are saturated.
module clipped_transparent_blit_top (
   input  logic                        clock,
   input  logic                        reset,
   // configuration write port
   input  logic                        csr_we,
   input  logic [ctb_pkg::IDX_W-1:0]   csr_index,
   input  logic [ctb_pkg::REG_W-1:0]   csr_wdata,
   // source pixel stream
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ctb_pkg::PIXEL_W-1:0] req_tdata,  // [7:0] source_pixel
   input  logic                        req_tuser,  // [0] first_pixel
   // framebuffer write stream
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ctb_pkg::ADDR_W+ctb_pkg::PIXEL_W-1:0] rsp_tdata
                                                   // [15:0] write_address,
                                                   // [23:16] write_pixel
);
   import ctb_pkg::*;

   logic          push;
   blit_item_type push_item;
   logic          queue_ready;
   logic          head_valid;
   blit_item_type head_item;
   logic          pop;

   // Front end: counters, clipping, color key
   ctb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .queue_ready (queue_ready),
      .push        (push),
      .push_item   (push_item)
   );

   // Hold surviving pixels until the back end can take them
   ctb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .ready      (queue_ready),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

   // Back end: address generation and output register
   ctb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
